>>> src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// widths, types and constants shared by the quaternion vector rotate unit
// and its port checker
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int VEC_W     = 32;  // vector component width, Q16.16 at 32
    localparam int Q_W       = 16;  // quaternion component width, Q2.14
    localparam int FRAC_DROP = 28;  // 44 fraction bits down to 16

    // component slots
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    // full precision widths through the datapath
    localparam int P1_W = VEC_W + Q_W;      // q * v
    localparam int C1_W = P1_W + 1;         // c1 = q x v
    localparam int P2_W = C1_W + Q_W;       // q * c1, w * c1
    localparam int C2_W = P2_W + 1;         // c2 = q x c1
    localparam int U_W  = C2_W + 1;         // w*c1 + c2
    localparam int T_W  = U_W + 3;          // v<<28 + 2u + half
    localparam int R_W  = T_W - FRAC_DROP;  // rounded, before saturation

    typedef logic signed [Q_W-1:0]   quat_t;
    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [P1_W-1:0]  p1_t;
    typedef logic signed [C1_W-1:0]  c1_t;
    typedef logic signed [P2_W-1:0]  p2_t;
    typedef logic signed [C2_W-1:0]  c2_t;
    typedef logic signed [U_W-1:0]   u_t;
    typedef logic signed [T_W-1:0]   t_t;

    localparam vec_t VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam vec_t VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

>>> src/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// rotates a Q16.16 vector by a Q2.14 quaternion: v + 2(w*c1 + c2),
// c1 = q x v, c2 = q x c1, rounded to nearest and saturated
// ----------------------------------------------------------------------------
// The unit takes one word per clock unless a stall at the output has
// backed up through every full stage to its input. The seven register
// stages are: first cross product multipliers, first cross product
// differences, second cross product and w multipliers, second cross product
// differences, the w*c1 + c2 sum, the final add with rounding, and the
// saturating output register. Each stage holds only while the stage after
// it is full and held, so bubbles close up and item_ready stays high while
// the output is empty. No normalization is applied to the quaternion; a
// tie in rounding goes toward plus infinity, and saturated is set when any
// component clips.
module quaternion_vector_rotate_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  qvr_pkg::quat_t quat_x,
    input  qvr_pkg::quat_t quat_y,
    input  qvr_pkg::quat_t quat_z,
    input  qvr_pkg::quat_t quat_w,
    input  qvr_pkg::vec_t  vec_x,
    input  qvr_pkg::vec_t  vec_y,
    input  qvr_pkg::vec_t  vec_z,
    output logic          rot_valid,
    input  logic          rot_ready,
    output qvr_pkg::vec_t  rot_x,
    output qvr_pkg::vec_t  rot_y,
    output qvr_pkg::vec_t  rot_z,
    output logic          saturated
);
    import qvr_pkg::*;

    localparam int   NSTAGE     = 7;
    localparam t_t   ROUND_HALF = t_t'(1) <<< (FRAC_DROP - 1);

    quat_t q_in [4];
    vec_t  v_in [3];

    logic [NSTAGE-1:1] vld_reg;
    logic              rot_valid_reg;
    logic [NSTAGE:1]   en;

    // stage 1
    p1_t   s1_pa_next [3];
    p1_t   s1_pb_next [3];
    p1_t   s1_pa_reg  [3];
    p1_t   s1_pb_reg  [3];
    quat_t s1_q_reg   [4];
    vec_t  s1_v_reg   [3];
    // stage 2
    c1_t   s2_c1_next [3];
    c1_t   s2_c1_reg  [3];
    quat_t s2_q_reg   [4];
    vec_t  s2_v_reg   [3];
    // stage 3
    p2_t   s3_ma_next [3];
    p2_t   s3_mb_next [3];
    p2_t   s3_wc_next [3];
    p2_t   s3_ma_reg  [3];
    p2_t   s3_mb_reg  [3];
    p2_t   s3_wc_reg  [3];
    vec_t  s3_v_reg   [3];
    // stage 4
    c2_t   s4_c2_next [3];
    c2_t   s4_c2_reg  [3];
    p2_t   s4_wc_reg  [3];
    vec_t  s4_v_reg   [3];
    // stage 5
    u_t    s5_u_next  [3];
    u_t    s5_u_reg   [3];
    vec_t  s5_v_reg   [3];
    // stage 6
    t_t    s6_tv      [3];
    t_t    s6_tu      [3];
    t_t    s6_t_next  [3];
    t_t    s6_t_reg   [3];
    // output stage
    vec_t  rot_next   [3];
    vec_t  rot_reg    [3];
    logic  sat_next;
    logic  sat_reg;

    assign q_in[IX] = quat_x;
    assign q_in[IY] = quat_y;
    assign q_in[IZ] = quat_z;
    assign q_in[IW] = quat_w;
    assign v_in[IX] = vec_x;
    assign v_in[IY] = vec_y;
    assign v_in[IZ] = vec_z;

    // a stage loads when it is empty or the next one loads
    always_comb
    begin
        en[NSTAGE] = !rot_valid_reg || rot_ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign item_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rot_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= item_valid;
            end
            for (int k = 2; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en[NSTAGE])
            begin
                rot_valid_reg <= vld_reg[NSTAGE-1];
            end
        end
    end

    // first cross product, multipliers
    always_comb
    begin
        s1_pa_next[IX] = q_in[IY] * v_in[IZ];
        s1_pb_next[IX] = q_in[IZ] * v_in[IY];
        s1_pa_next[IY] = q_in[IZ] * v_in[IX];
        s1_pb_next[IY] = q_in[IX] * v_in[IZ];
        s1_pa_next[IZ] = q_in[IX] * v_in[IY];
        s1_pb_next[IZ] = q_in[IY] * v_in[IX];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_c1_next[i] = c1_t'(s1_pa_reg[i]) - c1_t'(s1_pb_reg[i]);
        end
    end

    // second cross product and w scaling, multipliers
    always_comb
    begin
        s3_ma_next[IX] = s2_q_reg[IY] * s2_c1_reg[IZ];
        s3_mb_next[IX] = s2_q_reg[IZ] * s2_c1_reg[IY];
        s3_ma_next[IY] = s2_q_reg[IZ] * s2_c1_reg[IX];
        s3_mb_next[IY] = s2_q_reg[IX] * s2_c1_reg[IZ];
        s3_ma_next[IZ] = s2_q_reg[IX] * s2_c1_reg[IY];
        s3_mb_next[IZ] = s2_q_reg[IY] * s2_c1_reg[IX];
        for (int i = 0; i < 3; i++)
        begin
            s3_wc_next[i] = s2_q_reg[IW] * s2_c1_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_c2_next[i] = c2_t'(s3_ma_reg[i]) - c2_t'(s3_mb_reg[i]);
            s5_u_next[i]  = u_t'(s4_wc_reg[i]) + u_t'(s4_c2_reg[i]);
            s6_tv[i]      = t_t'(s5_v_reg[i]) <<< FRAC_DROP;
            s6_tu[i]      = t_t'(s5_u_reg[i]) <<< 1;
            s6_t_next[i]  = s6_tv[i] + s6_tu[i] + ROUND_HALF;
        end
    end

    // drop the fraction bits and clip to the vector range
    always_comb
    begin
        logic [R_W-VEC_W:0] hi;
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            hi = s6_t_reg[i][T_W-1:T_W-(R_W-VEC_W+1)];
            if (hi != '0 && hi != '1)
            begin
                sat_next    = 1'b1;
                rot_next[i] = hi[R_W-VEC_W] ? VEC_MIN : VEC_MAX;
            end
            else
            begin
                rot_next[i] = s6_t_reg[i][FRAC_DROP+VEC_W-1:FRAC_DROP];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_pa_reg <= s1_pa_next;
            s1_pb_reg <= s1_pb_next;
            s1_q_reg  <= q_in;
            s1_v_reg  <= v_in;
        end
        if (en[2])
        begin
            s2_c1_reg <= s2_c1_next;
            s2_q_reg  <= s1_q_reg;
            s2_v_reg  <= s1_v_reg;
        end
        if (en[3])
        begin
            s3_ma_reg <= s3_ma_next;
            s3_mb_reg <= s3_mb_next;
            s3_wc_reg <= s3_wc_next;
            s3_v_reg  <= s2_v_reg;
        end
        if (en[4])
        begin
            s4_c2_reg <= s4_c2_next;
            s4_wc_reg <= s3_wc_reg;
            s4_v_reg  <= s3_v_reg;
        end
        if (en[5])
        begin
            s5_u_reg <= s5_u_next;
            s5_v_reg <= s4_v_reg;
        end
        if (en[6])
        begin
            s6_t_reg <= s6_t_next;
        end
        if (en[7])
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign rot_valid = rot_valid_reg;
    assign rot_x     = rot_reg[IX];
    assign rot_y     = rot_reg[IY];
    assign rot_z     = rot_reg[IZ];
    assign saturated = sat_reg;

endmodule

>>> src/qvr_port_checker.sv
// ----------------------------------------------------------------------------
// qvr_port_checker
// port level checks on the quaternion vector rotate unit, bound to the top
// ----------------------------------------------------------------------------
module qvr_port_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_ready,
    input qvr_pkg::quat_t quat_x,
    input qvr_pkg::quat_t quat_y,
    input qvr_pkg::quat_t quat_z,
    input qvr_pkg::quat_t quat_w,
    input qvr_pkg::vec_t  vec_x,
    input qvr_pkg::vec_t  vec_y,
    input qvr_pkg::vec_t  vec_z,
    input logic           rot_valid,
    input logic           rot_ready,
    input qvr_pkg::vec_t  rot_x,
    input qvr_pkg::vec_t  rot_y,
    input qvr_pkg::vec_t  rot_z,
    input logic           saturated
);
    import qvr_pkg::*;

    // a held result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && !rot_ready |=> rot_valid)
        else $error("result word dropped while stalled");

    // a held result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && !rot_ready |=>
            $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(saturated))
        else $error("result payload changed while stalled");

    // with the output empty nothing can block the pipe
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rot_valid |-> item_ready)
        else $error("input stalled with empty output");

    // a clip flag must come with a component at a range limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && saturated |->
            rot_x == VEC_MAX || rot_x == VEC_MIN ||
            rot_y == VEC_MAX || rot_y == VEC_MIN ||
            rot_z == VEC_MAX || rot_z == VEC_MIN)
        else $error("saturated set with no clipped component");

endmodule

bind quaternion_vector_rotate_unit qvr_port_checker u_qvr_port_checker (.*);

>>> test/quaternion_vector_rotate_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_checker
// watches both channels of the rotate unit, works out the rotated vector
// for every accepted input word at full precision and compares each output
// word, field by field, with the oldest one still waiting
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           item_ready,
    input  qvr_pkg::quat_t quat_x,
    input  qvr_pkg::quat_t quat_y,
    input  qvr_pkg::quat_t quat_z,
    input  qvr_pkg::quat_t quat_w,
    input  qvr_pkg::vec_t  vec_x,
    input  qvr_pkg::vec_t  vec_y,
    input  qvr_pkg::vec_t  vec_z,
    input  logic           rot_valid,
    input  logic           rot_ready,
    input  qvr_pkg::vec_t  rot_x,
    input  qvr_pkg::vec_t  rot_y,
    input  qvr_pkg::vec_t  rot_z,
    input  logic           saturated,
    output int             errors,
    output int             pending
);
    import qvr_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
        logic sat;
    } rot_word_t;

    localparam wide_t WIDE_MAX = VEC_MAX;
    localparam wide_t WIDE_MIN = VEC_MIN;
    localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC_DROP - 1);

    rot_word_t expected_rot[$];
    rot_word_t want;
    int        word_count;

    initial errors = 0;

    task automatic report_error(input string msg);
        $display("checker: %s", msg);
        errors++;
    endtask

    // exact in 128 bits, the widest intermediate needs at most 70
    function automatic rot_word_t rotate_vector(
        input quat_t qx, input quat_t qy, input quat_t qz, input quat_t qw,
        input vec_t vx, input vec_t vy, input vec_t vz);
        wide_t     q[4];
        wide_t     v[3];
        wide_t     c1[3];
        wide_t     c2[3];
        wide_t     r[3];
        vec_t      o[3];
        logic      clip;
        int        k;
        rot_word_t word;
        q[IX] = qx;
        q[IY] = qy;
        q[IZ] = qz;
        q[IW] = qw;
        v[IX] = vx;
        v[IY] = vy;
        v[IZ] = vz;
        clip  = 1'b0;
        // cross products with the index rotated: a[k] = b[k+2]*q[k+1] - b[k+1]*q[k+2]
        for (k = 0; k < 3; k++)
            c1[k] = v[(k+2)%3] * q[(k+1)%3] - v[(k+1)%3] * q[(k+2)%3];
        for (k = 0; k < 3; k++)
            c2[k] = c1[(k+2)%3] * q[(k+1)%3] - c1[(k+1)%3] * q[(k+2)%3];
        for (k = 0; k < 3; k++)
        begin
            r[k] = ((v[k] <<< FRAC_DROP) + ((q[IW] * c1[k] + c2[k]) <<< 1) + HALF_LSB)
                   >>> FRAC_DROP;
            if (r[k] > WIDE_MAX)
            begin
                o[k] = VEC_MAX;
                clip = 1'b1;
            end
            else if (r[k] < WIDE_MIN)
            begin
                o[k] = VEC_MIN;
                clip = 1'b1;
            end
            else
                o[k] = r[k][VEC_W-1:0];
        end
        word.x   = o[IX];
        word.y   = o[IY];
        word.z   = o[IZ];
        word.sat = clip;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rot.delete();
            word_count = 0;
            pending    = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_rot.push_back(rotate_vector(quat_x, quat_y, quat_z, quat_w,
                                                     vec_x, vec_y, vec_z));
            if (rot_valid && rot_ready)
            begin
                if (expected_rot.size() == 0)
                    report_error($sformatf("word %0d: output word with nothing expected",
                                           word_count));
                else
                begin
                    want = expected_rot.pop_front();
                    if (rot_x !== want.x)
                        report_error($sformatf("word %0d: rot_x got %h want %h",
                                               word_count, rot_x, want.x));
                    if (rot_y !== want.y)
                        report_error($sformatf("word %0d: rot_y got %h want %h",
                                               word_count, rot_y, want.y));
                    if (rot_z !== want.z)
                        report_error($sformatf("word %0d: rot_z got %h want %h",
                                               word_count, rot_z, want.z));
                    if (saturated !== want.sat)
                        report_error($sformatf("word %0d: saturated got %b want %b",
                                               word_count, saturated, want.sat));
                end
                word_count++;
            end
            pending = expected_rot.size();
        end
    end

endmodule

>>> test/quaternion_vector_rotate_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit_test
// drives directed and random quaternion and vector words into the rotate
// unit with random idling on both sides, a long output hold-off and a full
// drain, and gives the verdict from the checker's error count
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_test;
    import qvr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 90;
    localparam int TAIL_CYCLES    = 20;

    logic  clk;
    logic  rst_n;
    logic  item_valid;
    logic  item_ready;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
    logic  rot_valid;
    logic  rot_ready;
    vec_t  rot_x;
    vec_t  rot_y;
    vec_t  rot_z;
    logic  saturated;

    int    errors;
    int    pending;
    int    quiet_cycles;
    bit    sender_idle;
    bit    sink_idle;
    bit    hold_req;

    quaternion_vector_rotate_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .rot_valid  (rot_valid),
        .rot_ready  (rot_ready),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z),
        .saturated  (saturated)
    );

    quaternion_vector_rotate_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .rot_valid  (rot_valid),
        .rot_ready  (rot_ready),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z),
        .saturated  (saturated),
        .errors     (errors),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (rot_valid && rot_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("quaternion_vector_rotate_unit_test: errors");
                $finish;
            end
        end
    end

    // output side: random stall bursts, plus one long hold on request
    initial
    begin : sink_proc
        int stall_left;
        rot_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && sink_idle && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                rot_ready <= 1'b0;
                stall_left--;
            end
            else
                rot_ready <= 1'b1;
        end
    end

    task automatic send_word(input quat_t qx, input quat_t qy, input quat_t qz,
                             input quat_t qw, input vec_t vx, input vec_t vy,
                             input vec_t vz);
        @(negedge clk);
        item_valid <= 1'b1;
        quat_x     <= qx;
        quat_y     <= qy;
        quat_z     <= qz;
        quat_w     <= qw;
        vec_x      <= vx;
        vec_y      <= vy;
        vec_z      <= vz;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic drain_results;
        @(negedge clk);
        item_valid <= 1'b0;
        wait (pending == 0);
    endtask

    function automatic quat_t rand_quat(input int kind);
        if (kind == 0)
            return quat_t'($urandom);
        return quat_t'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic vec_t rand_vec(input int kind);
        if (kind == 0)
            return vec_t'($urandom);
        if (kind == 1)
            return vec_t'($urandom_range(0, 2**21) - 2**20);
        case ($urandom_range(0, 4))
            0:       return VEC_MAX;
            1:       return VEC_MIN;
            2:       return '0;
            3:       return '1;
            default: return vec_t'(1);
        endcase
    endfunction

    task automatic send_random;
        int qk;
        int vk;
        int cat;
        cat = $urandom_range(0, 9);
        qk  = (cat <= 3 || cat == 8) ? 0 : 1;
        vk  = (cat <= 3 || cat == 7) ? 0 : (cat <= 6) ? 1 : 2;
        send_word(rand_quat(qk), rand_quat(qk), rand_quat(qk), rand_quat(qk),
                  rand_vec(vk), rand_vec(vk), rand_vec(vk));
        if (sender_idle && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 13));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        quat_x      = '0;
        quat_y      = '0;
        quat_z      = '0;
        quat_w      = '0;
        vec_x       = '0;
        vec_y       = '0;
        vec_z       = '0;
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        hold_req    = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, '0, '0, '0);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'sd65536, -32'sd65536, 32'sd12345);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd16384, VEC_MAX, VEC_MIN, '0);
        send_word(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd65536, 32'sd131072, 32'sd196608);
        // rounding ties, one upward and one that lands on zero
        send_word(16'sd0, 16'sd0, 16'sd8192, 16'sd8192, 32'sd1, '0, '0);
        send_word(16'sd0, 16'sd0, -16'sd8192, 16'sd8192, 32'sd1, '0, '0);
        send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, VEC_MAX, VEC_MAX, VEC_MAX);
        send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, VEC_MIN, VEC_MIN, VEC_MIN);
        send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, VEC_MAX, VEC_MAX, VEC_MAX);
        send_word(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, VEC_MIN, VEC_MAX, VEC_MIN);
        send_word(16'sd100, -16'sd200, 16'sd300, -16'sd400, '1, '1, '1);
        send_word(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 32'sd7, -32'sd7, VEC_MAX);
        send_word(16'sd0, 16'sd16384, 16'sd0, 16'sd0, VEC_MIN, '0, VEC_MAX);
        send_word(-16'sd1, -16'sd1, -16'sd1, -16'sd1, '1, '1, '1);
        send_word(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 32'sd65536, -32'sd65536, 32'sd65536);
        drain_results;

        sender_idle = 1'b1;
        sink_idle   = 1'b1;
        repeat (350)
            send_random;

        // long output hold-off while words keep coming back to back
        sender_idle = 1'b0;
        hold_req    = 1'b1;
        repeat (30)
            send_random;
        drain_results;

        sender_idle = 1'b1;
        repeat (270)
            send_random;

        // no idling on either side to finish
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        repeat (150)
            send_random;

        drain_results;
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("quaternion_vector_rotate_unit_test: clean");
        else
            $display("quaternion_vector_rotate_unit_test: errors");
        $finish;
    end

endmodule

>>> sim.f
src/qvr_pkg.sv
src/quaternion_vector_rotate_unit.sv
src/qvr_port_checker.sv
test/quaternion_vector_rotate_checker.sv
test/quaternion_vector_rotate_unit_test.sv
